/* hw/rtl/hiap_pkg.sv */
package hiap_pkg;

  // Table geometry.
  localparam int TABLE_SIZE  = 127;
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int STEP_W      = SLOT_W;

  // Word field widths.
  localparam int KEY_W       = 31;
  localparam int OUT_SLOT_W  = 7;
  localparam int OUT_PROBE_W = 7;
  localparam int CNT_W       = 16;

  // Reciprocal of the table size for the home slot computation. With a shift of
  // KEY_W the estimated quotient is at most one below the true quotient.
  localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified key on its way to the back.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] home;
  } hiap_item_t;

endpackage

/* hw/rtl/hiap_ifs.sv */
interface hiap_in_if import hiap_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] insert_key;

  modport source (output valid, output insert_key, input ready);
  modport sink   (input valid, input insert_key, output ready);
endinterface

interface hiap_out_if import hiap_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_SLOT_W-1:0]  slot;
  logic                   at_home;
  logic [OUT_PROBE_W-1:0] probes;
  logic                   table_full;
  logic [CNT_W-1:0]       home_before_first_collision;
  logic [CNT_W-1:0]       home_inserts;
  logic [CNT_W-1:0]       home_collisions;
  logic [CNT_W-1:0]       probe_first_hits;
  logic [CNT_W-1:0]       probe_multi_hits;

  modport source (
    output valid, output slot, output at_home, output probes, output table_full,
    output home_before_first_collision, output home_inserts, output home_collisions,
    output probe_first_hits, output probe_multi_hits,
    input ready
  );
  modport sink (
    input valid, input slot, input at_home, input probes, input table_full,
    input home_before_first_collision, input home_inserts, input home_collisions,
    input probe_first_hits, input probe_multi_hits,
    output ready
  );
endinterface

/* hw/rtl/hiap_ram.sv */
module hiap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/hiap_front.sv */
module hiap_front import hiap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hiap_in_if.sink     in_word,
  output logic        push_valid,
  input  logic        push_ready,
  output hiap_item_t  push_item
);

  logic                 s1_v_r, s1_v_nxt;
  logic [KEY_W-1:0]     s1_key_r;
  logic [2*KEY_W-1:0]   s1_prod_r;
  logic                 accept;
  logic [KEY_W-1:0]     quot;
  logic [KEY_W-1:0]     quot_x_size;
  logic [KEY_W-1:0]     rem_est;
  logic [KEY_W-1:0]     rem_fix;

  assign in_word.ready = !s1_v_r || push_ready;
  assign accept        = in_word.valid && in_word.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (push_ready) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // The first stage registers the key times the reciprocal.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r  <= in_word.insert_key;
      s1_prod_r <= (2*KEY_W)'(in_word.insert_key) * (2*KEY_W)'(RECIP);
    end
  end

  // The estimated quotient is exact or one short, so the remainder needs
  // at most one correcting subtract.
  assign quot        = s1_prod_r[2*KEY_W-1:KEY_W];
  assign quot_x_size = quot * KEY_W'(TABLE_SIZE);
  assign rem_est     = s1_key_r - quot_x_size;
  assign rem_fix     = (rem_est >= KEY_W'(TABLE_SIZE)) ? rem_est - KEY_W'(TABLE_SIZE)
                                                       : rem_est;

  assign push_valid     = s1_v_r;
  assign push_item.key  = s1_key_r;
  assign push_item.home = rem_fix[SLOT_W-1:0];

endmodule

/* hw/rtl/hiap_queue.sv */
module hiap_queue import hiap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  hiap_item_t  push_item,
  output logic        pop_valid,
  input  logic        pop_ready,
  output hiap_item_t  pop_item
);

  hiap_item_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

/* hw/rtl/hiap_back.sv */
module hiap_back import hiap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  hiap_item_t  pop_item,
  hiap_out_if.source  out_word
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_CHECK = 2'b10
  } bk_state_t;

  bk_state_t           state_r, state_nxt;
  logic [KEY_W-1:0]    key_r;
  logic [SLOT_W-1:0]   cur_idx_r, cur_idx_nxt;
  logic [SLOT_W-1:0]   right_r, right_nxt;
  logic [SLOT_W-1:0]   left_r, left_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [TABLE_SIZE-1:0] vld_r;
  logic                seen_r;
  logic [CNT_W-1:0]    hbfc_r, home_cnt_r, coll_r, pfirst_r, pmulti_r;

  logic                   out_v_r;
  logic [OUT_SLOT_W-1:0]  out_slot_r;
  logic                   out_home_r;
  logic [OUT_PROBE_W-1:0] out_probes_r;
  logic                   out_full_r;

  logic [SLOT_W-1:0]   rd_addr;
  logic [KEY_W-1:0]    rd_data;
  logic                slot_empty, at_end, out_free;
  logic                do_finish, advance, place, first_look;
  logic [STEP_W-1:0]   step_inc;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
    return (cnt == '1) ? cnt : cnt + 1'b1;
  endfunction

  hiap_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE), .ADDR_W(SLOT_W)) u_ram (
    .clk     (clk),
    .we      (place),
    .wr_addr (cur_idx_r),
    .wr_data (key_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // An entry never written since reset reads as empty through its valid bit.
  assign slot_empty = !vld_r[cur_idx_r] || (rd_data == '0);
  assign at_end     = (step_r == STEP_W'(TABLE_SIZE - 1));
  assign out_free   = !out_v_r || out_word.ready;
  assign first_look = (step_r == '0);
  assign do_finish  = (state_r == S_CHECK) && (slot_empty || at_end) && out_free;
  assign advance    = (state_r == S_CHECK) && !slot_empty && !at_end;
  assign place      = do_finish && slot_empty;
  assign pop_ready  = (state_r == S_IDLE);
  assign step_inc   = step_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    cur_idx_nxt = cur_idx_r;
    right_nxt   = right_r;
    left_nxt    = left_r;
    step_nxt    = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          state_nxt   = S_CHECK;
          cur_idx_nxt = pop_item.home;
          right_nxt   = pop_item.home;
          left_nxt    = pop_item.home;
          step_nxt    = '0;
        end
      end
      S_CHECK: begin
        if (do_finish) begin
          state_nxt = S_IDLE;
        end else if (advance) begin
          step_nxt = step_inc;
          if (step_inc[0]) begin
            right_nxt   = (right_r == SLOT_W'(TABLE_SIZE - 1)) ? '0 : right_r + 1'b1;
            cur_idx_nxt = right_nxt;
          end else begin
            left_nxt    = (left_r == '0) ? SLOT_W'(TABLE_SIZE - 1) : left_r - 1'b1;
            cur_idx_nxt = left_nxt;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // While waiting on the output the same entry is read again, so the data holds.
  assign rd_addr = cur_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      vld_r      <= '0;
      seen_r     <= 1'b0;
      hbfc_r     <= '0;
      home_cnt_r <= '0;
      coll_r     <= '0;
      pfirst_r   <= '0;
      pmulti_r   <= '0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (place) begin
        vld_r[cur_idx_r] <= 1'b1;
      end
      if (do_finish) begin
        if (first_look && slot_empty) begin
          home_cnt_r <= sat_inc(home_cnt_r);
          if (!seen_r) begin
            hbfc_r <= sat_inc(hbfc_r);
          end
        end else begin
          seen_r <= 1'b1;
          coll_r <= sat_inc(coll_r);
          if (slot_empty) begin
            if (step_r == STEP_W'(1)) begin
              pfirst_r <= sat_inc(pfirst_r);
            end else begin
              pmulti_r <= sat_inc(pmulti_r);
            end
          end
        end
        out_v_r <= 1'b1;
      end else if (out_word.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop_valid) begin
      key_r <= pop_item.key;
    end
    cur_idx_r <= cur_idx_nxt;
    right_r   <= right_nxt;
    left_r    <= left_nxt;
    step_r    <= step_nxt;
    if (do_finish) begin
      out_slot_r   <= slot_empty ? OUT_SLOT_W'(cur_idx_r) : '0;
      out_home_r   <= slot_empty && first_look;
      out_probes_r <= OUT_PROBE_W'(step_r);
      out_full_r   <= !slot_empty;
    end
  end

  // The counters change only when a result loads, so they show this word's values.
  assign out_word.valid                       = out_v_r;
  assign out_word.slot                        = out_slot_r;
  assign out_word.at_home                     = out_home_r;
  assign out_word.probes                      = out_probes_r;
  assign out_word.table_full                  = out_full_r;
  assign out_word.home_before_first_collision = hbfc_r;
  assign out_word.home_inserts                = home_cnt_r;
  assign out_word.home_collisions             = coll_r;
  assign out_word.probe_first_hits            = pfirst_r;
  assign out_word.probe_multi_hits            = pmulti_r;

  a_full_not_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_full_r) |-> (!out_home_r && out_slot_r == '0))
    else $error("full result carries a slot");

  a_home_no_probes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_home_r) |-> (out_probes_r == '0))
    else $error("home placement with probes");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (step_r <= STEP_W'(TABLE_SIZE - 1)))
    else $error("probe step beyond table");

  a_home_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (home_cnt_r >= $past(home_cnt_r)))
    else $error("home insert counter went down");

endmodule

/* hw/rtl/hash_insert_alternating_probe_top.sv */
// The probe unit checks one table entry per cycle and takes the next key from the queue
// only after it has finished with the last one and loaded its result word.
// The front accepts a new key every cycle until the two-entry queue fills.
// Reset clears the per-slot valid bits, the counters and the collision flag at once;
// the key memory itself is never swept, so keys are taken as soon as reset ends.
module hash_insert_alternating_probe_top import hiap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hiap_in_if.sink     in_word,
  hiap_out_if.source  out_word
);

  // The front registers the key and its reciprocal product, then finds the
  // home slot with one correcting subtract.
  logic        fr_valid;
  logic        fr_ready;
  hiap_item_t  fr_item;

  // The queue lets the front keep taking keys while the probe unit works
  // through a long probe sequence.
  logic        bk_valid;
  logic        bk_ready;
  hiap_item_t  bk_item;

  hiap_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item)
  );

  hiap_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_item   (bk_item)
  );

  // The back probes right and left of the home slot in turn, one table
  // entry per cycle, writes the key into the first empty entry once its output
  // register is free, and updates the statistics. Its output register lets it start
  // on the next key while a result word still waits to be taken.
  hiap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (bk_valid),
    .pop_ready (bk_ready),
    .pop_item  (bk_item),
    .out_word  (out_word)
  );

endmodule

/* test/hash_insert_alternating_probe_top_test.sv */
`timescale 1ns / 1ps

module hash_insert_alternating_probe_top_test;
  import hiap_pkg::*;

  // Clock, reset and run control.
  localparam int HALF_NS      = 6;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 16;
  localparam int RANDOM_ITEMS = 620;
  localparam int REPORT_MAX   = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Statistics counters, in the order in which the result word carries them.
  typedef enum int {
    STAT_HOME_FIRST,
    STAT_HOME,
    STAT_COLL,
    STAT_PROBE_ONE,
    STAT_PROBE_MULTI,
    STAT_COUNT
  } stat_e;

  // One result word, field for field as the output channel carries it.
  typedef struct packed {
    logic [OUT_SLOT_W-1:0]  slot;
    logic                   at_home;
    logic [OUT_PROBE_W-1:0] probes;
    logic                   table_full;
    logic [CNT_W-1:0]       home_first;
    logic [CNT_W-1:0]       home_total;
    logic [CNT_W-1:0]       collisions;
    logic [CNT_W-1:0]       first_probe;
    logic [CNT_W-1:0]       multi_probe;
  } insert_word_t;

  // One row of the directed table. A row with typed set carries its expected word;
  // every other row is checked against the predictor. A row with a repeat count
  // above one runs with idling switched off on both sides.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [31:0]      reps;
    logic             typed;
    insert_word_t     want;
  } dir_row_t;

  localparam int ROW_COUNT = 16;

  // The rows fall in three groups. The first five start from reset: the zero key
  // lands home at slot 0 but leaves it reading empty, key 127 then takes slot 0 for
  // good, the next zero key collides and lands on the first probe at slot 1, key
  // 128 takes slot 1 at home, and the zero key after it needs two probes and wraps
  // left to slot 126. The next group covers the key extremes, wrapping past both
  // ends of the table and a duplicate key. The last row is a run of zero keys
  // offered and taken with no idle cycles at all.
  localparam dir_row_t DIRECTED [ROW_COUNT] = '{
    '{31'd0, 32'd1, 1'b1, '{7'd0, 1'b1, 7'd0, 1'b0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0}},
    '{31'd127, 32'd1, 1'b1,
      '{7'd0, 1'b1, 7'd0, 1'b0, 16'd2, 16'd2, 16'd0, 16'd0, 16'd0}},
    '{31'd0, 32'd1, 1'b1,
      '{7'd1, 1'b0, 7'd1, 1'b0, 16'd2, 16'd2, 16'd1, 16'd1, 16'd0}},
    '{31'd128, 32'd1, 1'b1,
      '{7'd1, 1'b1, 7'd0, 1'b0, 16'd2, 16'd3, 16'd1, 16'd1, 16'd0}},
    '{31'd0, 32'd1, 1'b1,
      '{7'd126, 1'b0, 7'd2, 1'b0, 16'd2, 16'd3, 16'd2, 16'd1, 16'd1}},
    '{31'h7FFF_FFFF, 32'd1, 1'b0, '0},
    '{31'd1, 32'd1, 1'b0, '0},
    '{31'd126, 32'd1, 1'b0, '0},
    '{31'd253, 32'd1, 1'b0, '0},
    '{31'd635, 32'd1, 1'b0, '0},
    '{31'd128, 32'd1, 1'b0, '0},
    '{31'h4000_0000, 32'd1, 1'b0, '0},
    '{31'h5555_5555, 32'd1, 1'b0, '0},
    '{31'h2AAA_AAAA, 32'd1, 1'b0, '0},
    '{31'h7FFF_FFFF, 32'd1, 1'b0, '0},
    '{31'd0, 32'd60, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  hiap_in_if  in_word ();
  hiap_out_if out_word ();

  hash_insert_alternating_probe_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always #(HALF_NS) clk = ~clk;

  // The predictor's own copy of the table, the collision flag and the counters.
  logic [KEY_W-1:0] slot_store [TABLE_SIZE];
  logic             collision_seen;
  logic [CNT_W-1:0] stats [STAT_COUNT];
  int               occupied;

  // Expected words in the order their keys were accepted.
  insert_word_t pending_words [$];

  // Run control shared between the sender, the receiver and the checker.
  bit quiet;
  bit hold_req;
  int sent_words;
  int checked_words;
  int full_words;
  int longest_probe;
  int fail_count;

  function automatic void bump(input stat_e which);
    if (stats[which] != CNT_MAX) begin
      stats[which] = stats[which] + 1'b1;
    end
  endfunction

  // Places one key in the predictor's table and returns the word the block should
  // produce for it. The probe walk alternates right and left of the home slot.
  function automatic insert_word_t predict_insert(input logic [KEY_W-1:0] key);
    insert_word_t w;
    int unsigned home;
    int unsigned right;
    int unsigned left;
    int unsigned idx;
    int step;
    bit placed;
    w = '0;
    home = key % TABLE_SIZE;
    if (slot_store[home] == '0) begin
      slot_store[home] = key;
      if (key != '0) occupied++;
      w.slot = OUT_SLOT_W'(home);
      w.at_home = 1'b1;
      bump(STAT_HOME);
      if (!collision_seen) bump(STAT_HOME_FIRST);
    end else begin
      collision_seen = 1'b1;
      bump(STAT_COLL);
      right = home;
      left = home;
      placed = 1'b0;
      for (step = 1; step < TABLE_SIZE && !placed; step++) begin
        if (step % 2 == 1) begin
          right = (right + 1 == TABLE_SIZE) ? 0 : right + 1;
          idx = right;
        end else begin
          left = (left == 0) ? TABLE_SIZE - 1 : left - 1;
          idx = left;
        end
        if (slot_store[idx] == '0) begin
          slot_store[idx] = key;
          if (key != '0) occupied++;
          w.slot = OUT_SLOT_W'(idx);
          w.probes = OUT_PROBE_W'(step);
          placed = 1'b1;
          if (step == 1) begin
            bump(STAT_PROBE_ONE);
          end else begin
            bump(STAT_PROBE_MULTI);
          end
        end
      end
      // No empty slot anywhere: nothing is written and the word says so.
      if (!placed) begin
        w.table_full = 1'b1;
        w.probes = OUT_PROBE_W'(TABLE_SIZE - 1);
      end
    end
    w.home_first  = stats[STAT_HOME_FIRST];
    w.home_total  = stats[STAT_HOME];
    w.collisions  = stats[STAT_COLL];
    w.first_probe = stats[STAT_PROBE_ONE];
    w.multi_probe = stats[STAT_PROBE_MULTI];
    return w;
  endfunction

  function automatic string word_text(input insert_word_t w);
    return $sformatf("slot=%0d home=%0d probes=%0d full=%0d cnt=%0d/%0d/%0d/%0d/%0d",
                     w.slot, w.at_home, w.probes, w.table_full, w.home_first,
                     w.home_total, w.collisions, w.first_probe, w.multi_probe);
  endfunction

  // Random keys are mostly zero keys, which hunt for the nearest empty slot around
  // slot 0 without filling it, so the table fills slowly and the probe walks grow
  // long. The rest are full-width random keys and keys bunched on homes 0 to 3.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return KEY_W'($urandom);
    if (pick < 30) return KEY_W'($urandom_range(1, 16909320) * 127 + $urandom_range(0, 3));
    return '0;
  endfunction

  // Offers one key, waits for the handshake and records what the block owes for it.
  // The valid stays high from one word to the next unless an idle cycle falls between.
  task automatic send_key(input logic [KEY_W-1:0] key, input bit typed,
                          input insert_word_t want);
    insert_word_t predicted;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.insert_key <= key;
    do @(posedge clk); while (!in_word.ready);
    predicted = predict_insert(key);
    pending_words.push_back(typed ? want : predicted);
    sent_words++;
  endtask

  // Stops offering and waits until every word owed has come back.
  task automatic wait_all_drained();
    in_word.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Stimulus: reset, the directed table, then the random part.
  initial begin
    int n;
    rst_n <= 1'b0;
    in_word.valid <= 1'b0;
    in_word.insert_key <= '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    collision_seen = 1'b0;
    occupied = 0;
    foreach (slot_store[s]) slot_store[s] = '0;
    foreach (stats[s]) stats[s] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[r]) begin
      quiet = (DIRECTED[r].reps > 1);
      for (n = 0; n < DIRECTED[r].reps; n++) begin
        send_key(DIRECTED[r].key, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    quiet = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Once the receiver holds off for a long stretch while keys keep coming, so
      // the internal queue fills and the input stalls; later the sender stops
      // until every owed word has been returned.
      if (n == RANDOM_ITEMS / 4) hold_req = 1'b1;
      if (n == RANDOM_ITEMS / 2) wait_all_drained();
      send_key(pick_key(), 1'b0, '0);
    end

    // Make sure the table is full, then insert into it once more.
    while (occupied < TABLE_SIZE) begin
      send_key(KEY_W'($urandom_range(1, 32'h7FFF_FFFF)), 1'b0, '0);
    end
    send_key(pick_key(), 1'b0, '0);

    wait_all_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run sent %0d keys and checked %0d words: home, first-probe and multi-probe",
             sent_words, checked_words);
    $display("  placement, wrap at both table ends, %0d table-full words, longest walk %0d.",
             full_words, longest_probe);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: random idle cycles, none during the back-to-back run, and one long
  // hold-off that it counts down itself.
  initial begin
    int hold_left;
    hold_left = 0;
    out_word.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_word.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_word.ready <= 1'b0;
      end else begin
        out_word.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Checker: every accepted result word is matched with the oldest expected one.
  always @(posedge clk) begin
    insert_word_t seen;
    insert_word_t want;
    if (rst_n && out_word.valid && out_word.ready) begin
      seen = {out_word.slot, out_word.at_home, out_word.probes, out_word.table_full,
              out_word.home_before_first_collision, out_word.home_inserts,
              out_word.home_collisions, out_word.probe_first_hits,
              out_word.probe_multi_hits};
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("Unexpected result word: %s", word_text(seen));
        end
      end else begin
        want = pending_words.pop_front();
        checked_words++;
        if (seen !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("Word %0d mismatch: expected %s", checked_words, word_text(want));
            $display("                 actual   %s", word_text(seen));
          end
        end
        if (seen.table_full === 1'b1) full_words++;
        else if (int'(seen.probes) > longest_probe) longest_probe = seen.probes;
      end
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    int still_cycles;
    if (!rst_n || (in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
      still_cycles = 0;
    end else begin
      still_cycles++;
      if (still_cycles == LIMIT_CYCLES) begin
        $display("Timeout: no word moved for %0d cycles, %0d words still owed.",
                 LIMIT_CYCLES, pending_words.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
